### hw/rtl/ellipse_span_filler_assert.svh
// ----------------------------------------------------------------------------
// ellipse_span_filler_assert
// assertion macros shared by the ellipse span filler modules
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_SPAN_FILLER_ASSERT_SVH
`define ELLIPSE_SPAN_FILLER_ASSERT_SVH

// same-cycle implication
`define ESF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ESF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/esf_pkg.sv
// ----------------------------------------------------------------------------
// esf_pkg
// types and constants of the ellipse span filler
// ----------------------------------------------------------------------------
`default_nettype none

package esf_pkg;

	localparam int COORD_W   = 12;
	localparam int POS_W     = 13;
	localparam int WIDE_W    = 14;
	localparam int BW_W      = 12;
	localparam int BH_W      = 6;
	localparam int HW_W      = 11;
	localparam int HH_W      = 5;
	localparam int X_W       = 12;
	localparam int Y_W       = 6;
	localparam int A2_W      = 22;
	localparam int B2_W      = 10;
	localparam int ACC_W     = 40;
	localparam int COLOR_W   = 24;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLIP_LEFT   = 2'd0,
		REG_CLIP_TOP    = 2'd1,
		REG_CLIP_RIGHT  = 2'd2,
		REG_CLIP_BOTTOM = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEL_TOP,
		SEL_BOT,
		SEL_EXTRA
	} span_sel_t;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
	} clip_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col_first;
		logic [COORD_W-1:0] col_last;
		logic [COLOR_W-1:0] color;
	} span_t;

	typedef struct packed {
		logic      load;
		logic      square;
		logic      scale;
		logic      seed;
		logic      x_step;
		logic      y_step;
		span_sel_t sel;
	} walk_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic x_first;
		logic cond2;
		logic y_zero;
		logic hh_zero;
		logic visible;
	} walk_stat_t;

	typedef struct packed {
		logic load;
		logic flush;
	} out_cmd_t;

	typedef struct packed {
		logic pend_valid;
		logic out_free;
	} out_stat_t;

endpackage

`default_nettype wire

### hw/rtl/esf_walk.sv
// ----------------------------------------------------------------------------
// esf_walk
// error-walk datapath: setup products, walk registers, span build and clip
// ----------------------------------------------------------------------------
`default_nettype none

module esf_walk
	import esf_pkg::*;
#(
	parameter int MAX_HEIGHT = 63
) (
	input  wire logic                      clk,
	input  wire walk_cmd_t                 cmd,
	input  wire clip_t                     clip,
	input  wire logic signed [POS_W-1:0]   center_x,
	input  wire logic signed [POS_W-1:0]   center_y,
	input  wire logic        [BW_W-1:0]    box_width,
	input  wire logic        [BH_W-1:0]    box_height,
	input  wire logic        [COLOR_W-1:0] fill_color,
	output walk_stat_t                     stat,
	output span_t                          span
);

	logic signed [POS_W-1:0]   cx_q;
	logic signed [POS_W-1:0]   cy_q;
	logic        [HW_W-1:0]    hw_q;
	logic        [HH_W-1:0]    hh_q;
	logic        [COLOR_W-1:0] color_q;
	logic        [A2_W-1:0]    a2_q;
	logic        [B2_W-1:0]    b2_q;
	logic signed [ACC_W-1:0]   crit1_q;
	logic signed [ACC_W-1:0]   crit2_q;
	logic signed [ACC_W-1:0]   crit3_q;
	logic signed [ACC_W-1:0]   ay_q;
	logic signed [ACC_W-1:0]   bx_q;
	logic signed [ACC_W-1:0]   t_q;
	logic signed [ACC_W-1:0]   dxn_q;
	logic signed [ACC_W-1:0]   dyn_q;
	logic        [X_W-1:0]     x_q;
	logic signed [Y_W-1:0]     y_q;

	logic        [BH_W-1:0]       bh_sat;
	logic        [A2_W-1:0]       a2_d;
	logic        [B2_W-1:0]       b2_d;
	logic        [A2_W+HH_W-1:0]  ay_prod;
	logic signed [ACC_W-1:0]      a2_w;
	logic signed [ACC_W-1:0]      b2_w;
	logic signed [ACC_W-1:0]      a2x2_w;
	logic signed [ACC_W-1:0]      b2x2_w;
	logic signed [ACC_W-1:0]      sum_bx;
	logic signed [ACC_W-1:0]      sum_ay;
	logic signed [ACC_W-1:0]      dif_ay;
	logic signed [WIDE_W-1:0]     cx_w;
	logic signed [WIDE_W-1:0]     cy_w;
	logic signed [WIDE_W-1:0]     x_w;
	logic signed [WIDE_W-1:0]     y_w;
	logic signed [WIDE_W-1:0]     hw_w;
	logic signed [WIDE_W-1:0]     row_w;
	logic signed [WIDE_W-1:0]     c1_w;
	logic signed [WIDE_W-1:0]     c2_w;
	logic signed [WIDE_W-1:0]     left_w;
	logic signed [WIDE_W-1:0]     top_w;
	logic signed [WIDE_W-1:0]     right_w;
	logic signed [WIDE_W-1:0]     bottom_w;
	logic signed [WIDE_W-1:0]     c1_cl;
	logic signed [WIDE_W-1:0]     c2_cl;

	assign bh_sat  = (box_height > BH_W'(MAX_HEIGHT)) ? BH_W'(MAX_HEIGHT) : box_height;
	assign a2_d    = hw_q * hw_q;
	assign b2_d    = hh_q * hh_q;
	assign ay_prod = a2_q * hh_q;
	assign a2_w    = signed'(ACC_W'(a2_q));
	assign b2_w    = signed'(ACC_W'(b2_q));
	assign a2x2_w  = signed'(ACC_W'({a2_q, 1'b0}));
	assign b2x2_w  = signed'(ACC_W'({b2_q, 1'b0}));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			hw_q    <= box_width[BW_W-1:1];
			hh_q    <= bh_sat[BH_W-1:1];
			color_q <= fill_color;
		end
		if (cmd.square) begin
			a2_q <= a2_d;
			b2_q <= b2_d;
		end
		if (cmd.scale) begin
			ay_q    <= signed'(ACC_W'(ay_prod));
			crit1_q <= -(ACC_W'(a2_q >> 2) + ACC_W'(hw_q[0]) + ACC_W'(b2_q));
			crit2_q <= -(ACC_W'(b2_q >> 2) + ACC_W'(hh_q[0]) + ACC_W'(a2_q));
			crit3_q <= -(ACC_W'(b2_q >> 2) + ACC_W'(hh_q[0]));
		end
		if (cmd.seed) begin
			t_q   <= -ay_q;
			dyn_q <= a2x2_w - (ay_q <<< 1);
			dxn_q <= b2x2_w;
			bx_q  <= '0;
			x_q   <= '0;
			y_q   <= signed'(Y_W'(hh_q));
		end
		if (cmd.x_step) begin
			x_q   <= x_q + 1'b1;
			bx_q  <= bx_q + b2_w;
			t_q   <= t_q + dxn_q;
			dxn_q <= dxn_q + b2x2_w;
		end
		if (cmd.y_step) begin
			y_q   <= y_q - signed'(Y_W'(1));
			ay_q  <= ay_q - a2_w;
			t_q   <= t_q + dyn_q;
			dyn_q <= dyn_q + a2x2_w;
		end
	end

	assign sum_bx = t_q + bx_q;
	assign sum_ay = t_q + ay_q;
	assign dif_ay = t_q - ay_q;

	assign stat.walk_done = y_q[Y_W-1] || (x_q > X_W'(hw_q));
	assign stat.x_first   = (sum_bx <= crit1_q) || (sum_ay <= crit3_q);
	assign stat.cond2     = (dif_ay <= crit2_q);
	assign stat.y_zero    = (y_q == '0);
	assign stat.hh_zero   = (hh_q == '0);

	assign cx_w     = WIDE_W'(cx_q);
	assign cy_w     = WIDE_W'(cy_q);
	assign y_w      = WIDE_W'(y_q);
	assign x_w      = signed'(WIDE_W'(x_q));
	assign hw_w     = signed'(WIDE_W'(hw_q));
	assign left_w   = signed'(WIDE_W'(clip.left));
	assign top_w    = signed'(WIDE_W'(clip.top));
	assign right_w  = signed'(WIDE_W'(clip.right));
	assign bottom_w = signed'(WIDE_W'(clip.bottom));

	always_comb begin
		case (cmd.sel)
			SEL_TOP: begin
				row_w = cy_w - y_w;
				c1_w  = cx_w - x_w;
				c2_w  = cx_w + x_w;
			end
			SEL_BOT: begin
				row_w = cy_w + y_w;
				c1_w  = cx_w - x_w;
				c2_w  = cx_w + x_w;
			end
			SEL_EXTRA: begin
				row_w = cy_w;
				c1_w  = cx_w - hw_w;
				c2_w  = cx_w + hw_w + 14'sd1;
			end
			default: begin
				row_w = cy_w;
				c1_w  = cx_w;
				c2_w  = cx_w;
			end
		endcase
	end

	assign stat.visible = (left_w <= right_w) && (top_w <= bottom_w)
		&& (row_w >= top_w) && (row_w <= bottom_w)
		&& (c1_w <= right_w) && (c2_w >= left_w);

	assign c1_cl = (c1_w < left_w) ? left_w : ((c1_w > right_w) ? right_w : c1_w);
	assign c2_cl = (c2_w < left_w) ? left_w : ((c2_w > right_w) ? right_w : c2_w);

	assign span.row       = row_w[COORD_W-1:0];
	assign span.col_first = c1_cl[COORD_W-1:0];
	assign span.col_last  = c2_cl[COORD_W-1:0];
	assign span.color     = color_q;

endmodule

`default_nettype wire

### hw/rtl/esf_out.sv
// ----------------------------------------------------------------------------
// esf_out
// span hold stage and output register; the held span becomes last on flush
// ----------------------------------------------------------------------------
`default_nettype none
`include "ellipse_span_filler_assert.svh"

module esf_out
	import esf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire out_cmd_t            cmd,
	input  wire span_t               span_in,
	output out_stat_t                stat,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [COORD_W-1:0]       span_row,
	output logic [COORD_W-1:0]       span_start,
	output logic [COORD_W-1:0]       span_end,
	output logic [COLOR_W-1:0]       span_color,
	output logic                     last_span
);

	logic  pend_valid_q;
	logic  out_valid_q;
	logic  out_last_q;
	span_t pend_q;
	span_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
				end
				pend_valid_q <= 1'b1;
			end
			if (cmd.flush) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pend_q <= span_in;
			if (pend_valid_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end
		if (cmd.flush) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign span_row   = out_q.row;
	assign span_start = out_q.col_first;
	assign span_end   = out_q.col_last;
	assign span_color = out_q.color;
	assign last_span  = out_last_q;

	`ESF_ASSERT_SAME(a_no_overrun, clk, arst_n, (cmd.load && pend_valid_q), (!out_valid_q || out_ready), "held word pushed onto a busy output")
	`ESF_ASSERT_SAME(a_flush_has_word, clk, arst_n, (cmd.flush), (pend_valid_q && (!out_valid_q || out_ready) && !cmd.load), "flush without a held word or with a busy output")
	`ESF_ASSERT_NEXT(a_flush_marks_last, clk, arst_n, (cmd.flush), (out_valid_q && out_last_q && !pend_valid_q), "flush did not present a last word")

endmodule

`default_nettype wire

### hw/rtl/esf_ctrl.sv
// ----------------------------------------------------------------------------
// esf_ctrl
// sequencer for setup, error walk, span emission and final flush
// ----------------------------------------------------------------------------
`default_nettype none
`include "ellipse_span_filler_assert.svh"

module esf_ctrl
	import esf_pkg::*;
#(
	parameter int MAX_HEIGHT = 63
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire walk_stat_t wstat,
	input  wire out_stat_t  ostat,
	output walk_cmd_t       wcmd,
	output out_cmd_t        ocmd
);

	localparam int CNT_W = $clog2(MAX_HEIGHT + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SCALE,
		ST_SEED,
		ST_WALK,
		ST_EMIT_TOP,
		ST_EMIT_BOT,
		ST_ROW_X,
		ST_ROW_Y,
		ST_EXTRA,
		ST_FLUSH
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic [CNT_W-1:0]   n_q;
	logic               emit_state;
	logic               emit_ok;
	logic               emit_stall;

	assign emit_state = (state_q == ST_EMIT_TOP) || (state_q == ST_EMIT_BOT)
		|| (state_q == ST_EXTRA);
	assign emit_ok    = wstat.visible && (n_q < CNT_W'(MAX_HEIGHT));
	assign emit_stall = emit_ok && ostat.pend_valid && !ostat.out_free;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		wcmd       = '0;
		wcmd.sel   = SEL_TOP;
		ocmd       = '0;
		ocmd.load  = emit_state && emit_ok && !emit_stall;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				wcmd.load = in_valid;
				if (in_valid) begin
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				wcmd.square = 1'b1;
				state_d     = ST_SCALE;
			end
			ST_SCALE: begin
				wcmd.scale = 1'b1;
				state_d    = ST_SEED;
			end
			ST_SEED: begin
				wcmd.seed = 1'b1;
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				if (wstat.walk_done) begin
					state_d = wstat.hh_zero ? ST_EXTRA : ST_FLUSH;
				end else if (wstat.x_first) begin
					wcmd.x_step = 1'b1;
				end else begin
					state_d = ST_EMIT_TOP;
				end
			end
			ST_EMIT_TOP: begin
				wcmd.sel = SEL_TOP;
				if (!emit_stall) begin
					state_d = wstat.y_zero ? ST_ROW_X : ST_EMIT_BOT;
				end
			end
			ST_EMIT_BOT: begin
				wcmd.sel = SEL_BOT;
				if (!emit_stall) begin
					state_d = ST_ROW_X;
				end
			end
			ST_ROW_X: begin
				wcmd.x_step = wstat.cond2;
				state_d     = ST_ROW_Y;
			end
			ST_ROW_Y: begin
				wcmd.y_step = 1'b1;
				state_d     = ST_WALK;
			end
			ST_EXTRA: begin
				wcmd.sel = SEL_EXTRA;
				if (!emit_stall) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!ostat.pend_valid) begin
					state_d = ST_IDLE;
				end else if (ostat.out_free) begin
					ocmd.flush = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (wcmd.load) begin
				n_q <= '0;
			end else if (ocmd.load) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	`ESF_ASSERT_SAME(a_height_cap, clk, arst_n, (ocmd.load), (n_q < CNT_W'(MAX_HEIGHT)), "span count beyond height cap")
	`ESF_ASSERT_SAME(a_idle_quiet, clk, arst_n, (state_q == ST_IDLE), (!ocmd.load && !ocmd.flush && !wcmd.x_step && !wcmd.y_step), "walk or output activity while idle")

endmodule

`default_nettype wire

### hw/rtl/ellipse_span_filler.sv
// ----------------------------------------------------------------------------
// ellipse_span_filler
// filled-ellipse span generator: integer error walk from the top row to the
// center row, mirrored spans clipped to a programmable rectangle
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  in        in_valid/in_ready, center_x..fill_color       request words in
//  out       out_valid/out_ready, span_row..last_span      span words out
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data       clip registers
//
//  one request at a time; setup runs the square, scale and seed steps, then
//  the error-walk sequencer advances one column or one row per step, and
//  output stalls on an emitted span can hold it
//  the output register lets the next request start while a span waits
//  reset idles the sequencer, empties the output stage and opens the clip window
// ----------------------------------------------------------------------------
`default_nettype none

module ellipse_span_filler
	import esf_pkg::*;
#(
	parameter int MAX_HEIGHT = 63
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [POS_W-1:0]   center_x,
	input  wire logic signed [POS_W-1:0]   center_y,
	input  wire logic        [BW_W-1:0]    box_width,
	input  wire logic        [BH_W-1:0]    box_height,
	input  wire logic        [COLOR_W-1:0] fill_color,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic             [COORD_W-1:0] span_row,
	output logic             [COORD_W-1:0] span_start,
	output logic             [COORD_W-1:0] span_end,
	output logic             [COLOR_W-1:0] span_color,
	output logic                           last_span,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic      [CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [COORD_W-1:0] cfg_data
);

	clip_t      clip_q;
	walk_cmd_t  wcmd;
	walk_stat_t wstat;
	out_cmd_t   ocmd;
	out_stat_t  ostat;
	span_t      span;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q.left   <= '0;
			clip_q.top    <= '0;
			clip_q.right  <= '1;
			clip_q.bottom <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CLIP_LEFT:   clip_q.left   <= cfg_data;
				REG_CLIP_TOP:    clip_q.top    <= cfg_data;
				REG_CLIP_RIGHT:  clip_q.right  <= cfg_data;
				REG_CLIP_BOTTOM: clip_q.bottom <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	esf_ctrl #(
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.wstat    (wstat),
		.ostat    (ostat),
		.wcmd     (wcmd),
		.ocmd     (ocmd)
	);

	esf_walk #(
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_walk (
		.clk        (clk),
		.cmd        (wcmd),
		.clip       (clip_q),
		.center_x   (center_x),
		.center_y   (center_y),
		.box_width  (box_width),
		.box_height (box_height),
		.fill_color (fill_color),
		.stat       (wstat),
		.span       (span)
	);

	esf_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ocmd),
		.span_in    (span),
		.stat       (ostat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.span_row   (span_row),
		.span_start (span_start),
		.span_end   (span_end),
		.span_color (span_color),
		.last_span  (last_span)
	);

endmodule

`default_nettype wire

### dv/ellipse_span_filler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_span_filler_checker
// watches the request, span and clip channels of the ellipse span filler,
// works out the clipped spans of every accepted request and compares each
// span word that leaves the block with the oldest one still due
// ----------------------------------------------------------------------------

module ellipse_span_filler_checker
	import esf_pkg::*;
#(
	parameter int MAX_HEIGHT = 63
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic signed [POS_W-1:0]   center_x,
	input  logic signed [POS_W-1:0]   center_y,
	input  logic        [BW_W-1:0]    box_width,
	input  logic        [BH_W-1:0]    box_height,
	input  logic        [COLOR_W-1:0] fill_color,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic        [COORD_W-1:0] span_row,
	input  logic        [COORD_W-1:0] span_start,
	input  logic        [COORD_W-1:0] span_end,
	input  logic        [COLOR_W-1:0] span_color,
	input  logic                      last_span,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic      [CFG_IDX_W-1:0] cfg_index,
	input  logic        [COORD_W-1:0] cfg_data,
	input  logic                      end_of_test,
	output int                        fail_count,
	output int                        words_due
);

	localparam longint QUARTER = 4;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col_first;
		logic [COORD_W-1:0] col_last;
		logic [COLOR_W-1:0] color;
		logic               tail;
	} span_word_t;

	longint     win_left;
	longint     win_top;
	longint     win_right;
	longint     win_bottom;
	span_word_t spans_due[$];
	span_word_t fresh_spans[$];
	span_word_t got;
	span_word_t want;
	logic       leftover_seen;

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		fail_count++;
	endtask

	// clip one span against the window and keep it if any pixel shows and the height cap is not reached
	function automatic void add_visible_span(longint row, longint c1, longint c2,
			logic [COLOR_W-1:0] color);
		span_word_t w;
		if (fresh_spans.size() >= MAX_HEIGHT)
			return;
		if (win_left > win_right || win_top > win_bottom)
			return;
		if (row < win_top || row > win_bottom)
			return;
		if (c1 > win_right || c2 < win_left)
			return;
		if (c1 < win_left)
			c1 = win_left;
		if (c2 > win_right)
			c2 = win_right;
		w.row       = row[COORD_W-1:0];
		w.col_first = c1[COORD_W-1:0];
		w.col_last  = c2[COORD_W-1:0];
		w.color     = color;
		w.tail      = 1'b0;
		fresh_spans.push_back(w);
	endfunction

	// integer error walk from the top row down to the center row
	function automatic void predict_spans(logic signed [POS_W-1:0] cx_in,
			logic signed [POS_W-1:0] cy_in, logic [BW_W-1:0] bw, logic [BH_W-1:0] bh,
			logic [COLOR_W-1:0] color);
		longint     cx, cy, hw, hh, a2, b2, crit1, crit2, crit3;
		longint     d2xt, d2yt, x, y, wid, t, dxt, dyt, c1, c2;
		span_word_t w;
		cx = cx_in;
		cy = cy_in;
		hw = bw / 2;
		hh = (bh > MAX_HEIGHT ? MAX_HEIGHT : bh) / 2;
		a2 = hw * hw;
		b2 = hh * hh;
		crit1 = -(a2 / QUARTER + hw % 2 + b2);
		crit2 = -(b2 / QUARTER + hh % 2 + a2);
		crit3 = -(b2 / QUARTER + hh % 2);
		d2xt = 2 * b2;
		d2yt = 2 * a2;
		x = 0;
		y = hh;
		wid = 1;
		t = -a2 * y;
		dxt = 0;
		dyt = -2 * a2 * y;
		fresh_spans.delete();
		while (y >= 0 && x <= hw) begin
			if (t + b2 * x <= crit1 || t + a2 * y <= crit3) begin
				x += 1;
				dxt += d2xt;
				t += dxt;
				wid += 2;
			end else begin
				c1 = cx - x;
				c2 = cx - x + wid - 1;
				add_visible_span(cy - y, c1, c2, color);
				if (y != 0)
					add_visible_span(cy + y, c1, c2, color);
				if (t - a2 * y <= crit2) begin
					x += 1;
					dxt += d2xt;
					t += dxt;
					wid += 2;
				end
				y -= 1;
				dyt += d2yt;
				t += dyt;
			end
		end
		// flat ellipse: one more span on the center row
		if (hh == 0)
			add_visible_span(cy, cx - hw, cx + hw + 1, color);
		if (fresh_spans.size() > 0) begin
			w = fresh_spans.pop_back();
			w.tail = 1'b1;
			fresh_spans.push_back(w);
		end
		foreach (fresh_spans[i])
			spans_due.push_back(fresh_spans[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left = 0;
			win_top = 0;
			win_right = 4095;
			win_bottom = 4095;
			spans_due.delete();
			leftover_seen = 1'b0;
			fail_count = 0;
			words_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_CLIP_LEFT:   win_left = cfg_data;
					REG_CLIP_TOP:    win_top = cfg_data;
					REG_CLIP_RIGHT:  win_right = cfg_data;
					REG_CLIP_BOTTOM: win_bottom = cfg_data;
					default:         ;
				endcase
			end
			if (in_valid && in_ready)
				predict_spans(center_x, center_y, box_width, box_height, fill_color);
			if (out_valid && out_ready) begin
				got.row       = span_row;
				got.col_first = span_start;
				got.col_last  = span_end;
				got.color     = span_color;
				got.tail      = last_span;
				if (spans_due.size() == 0) begin
					flag_mismatch($sformatf("span word row %0d cols %0d..%0d with none due",
						got.row, got.col_first, got.col_last));
				end else begin
					want = spans_due.pop_front();
					if (got.row !== want.row || got.col_first !== want.col_first
							|| got.col_last !== want.col_last || got.color !== want.color
							|| got.tail !== want.tail)
						flag_mismatch($sformatf(
							"got row %0d cols %0d..%0d color %06h last %b, want row %0d cols %0d..%0d color %06h last %b",
							got.row, got.col_first, got.col_last, got.color, got.tail,
							want.row, want.col_first, want.col_last, want.color, want.tail));
				end
			end
			if (end_of_test && !leftover_seen) begin
				leftover_seen = 1'b1;
				if (spans_due.size() != 0)
					flag_mismatch($sformatf("%0d span words never came out", spans_due.size()));
			end
			words_due <= spans_due.size();
		end
	end

endmodule

### dv/ellipse_span_filler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_span_filler_test
// drives filled-ellipse requests and clip register writes into the span
// filler under changing idle patterns and a long output stall; the checker
// beside the block predicts and compares every span word
// ----------------------------------------------------------------------------

module ellipse_span_filler_test
	import esf_pkg::*;
();

	localparam int QUIET_LIMIT = 20000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [POS_W-1:0]   center_x = '0;
	logic signed [POS_W-1:0]   center_y = '0;
	logic        [BW_W-1:0]    box_width = '0;
	logic        [BH_W-1:0]    box_height = '0;
	logic        [COLOR_W-1:0] fill_color = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic        [COORD_W-1:0] span_row;
	logic        [COORD_W-1:0] span_start;
	logic        [COORD_W-1:0] span_end;
	logic        [COLOR_W-1:0] span_color;
	logic                      last_span;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic      [CFG_IDX_W-1:0] cfg_index = '0;
	logic        [COORD_W-1:0] cfg_data = '0;
	logic                      end_of_test = 1'b0;
	logic                      hold_go = 1'b0;
	logic                      hold_used = 1'b0;
	int                        hold_left = 0;
	int                        fail_count;
	int                        words_due;
	int                        send_idle_pct = 8;
	int                        recv_idle_pct = 80;
	int                        last_busy = 64;
	int                        quiet_cycles = 0;
	int                        win_l = 0;
	int                        win_t = 0;
	int                        win_r = 4095;
	int                        win_b = 4095;

	ellipse_span_filler uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.center_x(center_x), .center_y(center_y), .box_width(box_width),
		.box_height(box_height), .fill_color(fill_color),
		.out_valid(out_valid), .out_ready(out_ready),
		.span_row(span_row), .span_start(span_start), .span_end(span_end),
		.span_color(span_color), .last_span(last_span),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ellipse_span_filler_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.center_x(center_x), .center_y(center_y), .box_width(box_width),
		.box_height(box_height), .fill_color(fill_color),
		.out_valid(out_valid), .out_ready(out_ready),
		.span_row(span_row), .span_start(span_start), .span_end(span_end),
		.span_color(span_color), .last_span(last_span),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.end_of_test(end_of_test), .fail_count(fail_count), .words_due(words_due)
	);

	always #5 clk = ~clk;

	// span sink with one long stall on request
	always @(posedge clk) begin
		if (hold_go && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= 400;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_request(input int cx, input int cy, input int bw, input int bh,
			input int color);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		center_x   <= cx[POS_W-1:0];
		center_y   <= cy[POS_W-1:0];
		box_width  <= bw[BW_W-1:0];
		box_height <= bh[BH_W-1:0];
		fill_color <= color[COLOR_W-1:0];
		last_busy = 8 + bw / 2 + 5 * (bh / 2) + 32;
		do @(posedge clk); while (!in_ready);
	endtask

	// mostly centered around the clip window, sometimes anywhere
	task automatic send_random();
		int lo, hi, cx, cy, bw, pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			cx = $urandom_range(8191);
			cy = $urandom_range(8191);
			cx = cx - 4096;
			cy = cy - 4096;
		end else begin
			lo = (win_l < win_r ? win_l : win_r) - 64;
			hi = (win_l < win_r ? win_r : win_l) + 64;
			cx = $urandom_range(hi - lo);
			cx = lo + cx;
			lo = (win_t < win_b ? win_t : win_b) - 40;
			hi = (win_t < win_b ? win_b : win_t) + 40;
			cy = $urandom_range(hi - lo);
			cy = lo + cy;
			if (cx > 4095)
				cx = 4095;
			if (cy > 4095)
				cy = 4095;
		end
		pick = $urandom_range(99);
		if (pick < 70)
			bw = $urandom_range(63);
		else if (pick < 92)
			bw = $urandom_range(511);
		else
			bw = $urandom_range(4095);
		send_request(cx, cy, bw, $urandom_range(63), $urandom_range(24'hFFFFFF));
	endtask

	task automatic send_burst(input int count);
		repeat (count) send_random();
	endtask

	// block idle: all spans out and the last walk given time to finish
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_due != 0);
		repeat (last_busy) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[COORD_W-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_clip(input int l, input int t, input int r, input int b);
		write_reg(REG_CLIP_LEFT, l);
		write_reg(REG_CLIP_TOP, t);
		write_reg(REG_CLIP_RIGHT, r);
		write_reg(REG_CLIP_BOTTOM, b);
		cfg_valid <= 1'b0;
		win_l = l;
		win_t = t;
		win_r = r;
		win_b = b;
	endtask

	task automatic program_random_clip();
		int a, b, c, d;
		a = $urandom_range(4095);
		b = $urandom_range(4095);
		c = $urandom_range(4095);
		d = $urandom_range(4095);
		program_clip(a < b ? a : b, c < d ? c : d, a < b ? b : a, c < d ? d : c);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window
		send_request(0, 0, 0, 0, 0);
		send_request(4095, 4095, 4095, 63, 24'hFFFFFF);
		send_request(-4096, -4096, 4095, 63, 24'h123456);
		send_request(2048, 2048, 4095, 63, 24'hAAAAAA);
		send_request(1000, 1000, 4094, 62, 24'h555555);
		send_request(100, 50, 200, 0, 24'h0F0F0F);
		send_request(100, 60, 201, 1, 24'hF0F0F0);
		send_request(-10, 20, 40, 30, 24'h00FF00);
		send_request(20, -5, 30, 20, 24'hFF0000);
		send_request(50, 50, 1, 1, 24'h0000FF);
		send_request(50, 50, 2, 2, 24'h808080);
		send_request(60, 60, 7, 9, 24'h7F7F7F);
		send_request(4093, 4090, 21, 13, 24'h010203);
		send_request(200, -20, 30, 63, 24'hC0FFEE);
		settle();

		program_clip(100, 200, 300, 400);
		send_request(100, 200, 60, 40, 24'h111111);
		send_request(300, 400, 60, 40, 24'h222222);
		send_request(200, 300, 4095, 63, 24'h333333);
		send_request(200, 190, 20, 0, 24'h444444);
		send_request(200, 200, 20, 1, 24'h555555);
		settle();

		// inverted windows hide everything
		program_clip(4095, 0, 0, 4095);
		send_request(200, 300, 100, 20, 24'h666666);
		settle();
		program_clip(0, 4095, 4095, 0);
		send_request(200, 300, 100, 20, 24'h777777);
		settle();

		// one-pixel window in the far corner
		program_clip(4095, 4095, 4095, 4095);
		send_request(4095, 4095, 10, 10, 24'h888888);
		send_request(4095, 4095, 0, 0, 24'h999999);
		settle();

		program_clip(0, 0, 4095, 4095);
		send_burst(90);
		settle();

		send_idle_pct = 80;
		recv_idle_pct <= 8;
		program_random_clip();
		send_burst(90);
		settle();

		send_idle_pct = 0;
		recv_idle_pct <= 0;
		program_clip(4000, 4000, 4095, 4095);
		hold_go <= 1'b1;
		send_burst(30);
		in_valid <= 1'b0;
		do @(posedge clk); while (words_due != 0);
		send_burst(60);
		settle();

		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
